/* sv/sahss_pkg.sv */
// ----------------------------------------------------------------------------
// sahss_pkg - shared types and helpers for the SAH split sweep
// Box, request, result and sequencer command types plus box helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sahss_pkg;

   localparam int MaxLeaves = 1024;
   localparam int IdxBits   = $clog2(MaxLeaves);
   localparam int CntBits   = IdxBits + 1;
   localparam int CoordBits = 16;

   localparam logic signed [CoordBits-1:0] CoordMax = {1'b0, {(CoordBits-1){1'b1}}};
   localparam logic signed [CoordBits-1:0] CoordMin = {1'b1, {(CoordBits-1){1'b0}}};

   localparam logic [1:0] AxisX    = 2'd0;
   localparam logic [1:0] AxisZ    = 2'd2;
   localparam logic [1:0] AxisNone = 2'd3;

   typedef struct packed {
      logic signed [CoordBits-1:0] lo_x;
      logic signed [CoordBits-1:0] lo_y;
      logic signed [CoordBits-1:0] lo_z;
      logic signed [CoordBits-1:0] hi_x;
      logic signed [CoordBits-1:0] hi_y;
      logic signed [CoordBits-1:0] hi_z;
   } box_type;

   typedef struct packed {
      logic [1:0]         axis;
      logic signed [15:0] box_min_x;
      logic signed [15:0] box_min_y;
      logic signed [15:0] box_min_z;
      logic signed [15:0] box_max_x;
      logic signed [15:0] box_max_y;
      logic signed [15:0] box_max_z;
      logic               last_of_axis;
   } req_type;

   typedef struct packed {
      logic [1:0]         best_axis;
      logic [9:0]         split_pos;
      logic               side;
      logic signed [15:0] out_min_x;
      logic signed [15:0] out_min_y;
      logic signed [15:0] out_min_z;
      logic signed [15:0] out_max_x;
      logic signed [15:0] out_max_y;
      logic signed [15:0] out_max_z;
      logic               last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SUF_RD, ST_SUF_WR, ST_FW_RD, ST_FW_UNI,
      ST_COST, ST_CMP, ST_EMIT_L, ST_EMIT_R
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_STORE, OP_SUF_RD, OP_SUF_WR, OP_FW_RD,
      OP_FW_UNI, OP_COST, OP_CMP, OP_CLEAR
   } op_type;

   // cost micro-steps: three extent products, base cost, count scaling
   typedef enum logic [2:0] {
      CS_E01, CS_E12, CS_E20, CS_BASE, CS_SCALE
   } cstep_type;

   typedef struct packed {
      op_type              op;
      cstep_type           step;
      logic                side;
      logic [IdxBits-1:0]  idx;
      logic [CntBits-1:0]  cnt;
      logic [1:0]          axis;
      logic                out_side;
   } cmd_type;

   function automatic box_type empty_box();
      box_type b;
      b.lo_x = CoordMax; b.lo_y = CoordMax; b.lo_z = CoordMax;
      b.hi_x = CoordMin; b.hi_y = CoordMin; b.hi_z = CoordMin;
      return b;
   endfunction

   function automatic box_type unite(box_type a, box_type b);
      box_type r;
      r.lo_x = (b.lo_x < a.lo_x) ? b.lo_x : a.lo_x;
      r.lo_y = (b.lo_y < a.lo_y) ? b.lo_y : a.lo_y;
      r.lo_z = (b.lo_z < a.lo_z) ? b.lo_z : a.lo_z;
      r.hi_x = (b.hi_x > a.hi_x) ? b.hi_x : a.hi_x;
      r.hi_y = (b.hi_y > a.hi_y) ? b.hi_y : a.hi_y;
      r.hi_z = (b.hi_z > a.hi_z) ? b.hi_z : a.hi_z;
      return r;
   endfunction

   // extent hi-lo, negative counts as zero
   function automatic logic [CoordBits-1:0] extent(logic signed [CoordBits-1:0] hi,
                                                   logic signed [CoordBits-1:0] lo);
      logic signed [CoordBits:0] d;
      d = (CoordBits+1)'(hi) - (CoordBits+1)'(lo);
      return (d > 0) ? d[CoordBits-1:0] : '0;
   endfunction

endpackage

`default_nettype wire

/* sv/sahss_dp.sv */
// ----------------------------------------------------------------------------
// sahss_dp - datapath of the SAH split sweep
// Box and suffix memories, prefix union, shared cost multiplier, best split.
// ----------------------------------------------------------------------------
`default_nettype none

module sahss_dp (
   input  wire                  clock,
   input  wire                  reset,
   input  sahss_pkg::cmd_type   cmd,
   input  sahss_pkg::req_type   req,
   input  wire                  csr_wr_en,
   input  wire                  csr_wr_data,
   output sahss_pkg::rsp_type   rsp
);

   // memories
   sahss_pkg::box_type box_mem [sahss_pkg::MaxLeaves];
   sahss_pkg::box_type suf_mem [sahss_pkg::MaxLeaves];

   sahss_pkg::box_type box_rd_ff;
   sahss_pkg::box_type suf_rd_ff;
   sahss_pkg::box_type acc_ff,   acc_in;
   sahss_pkg::box_type pre_ff,   pre_in;
   sahss_pkg::box_type right_ff;
   sahss_pkg::box_type best_l_ff, best_r_ff;
   logic [63:0] best_cost_ff;
   logic [1:0]  best_axis_ff;
   logic [sahss_pkg::IdxBits-1:0] best_split_ff;
   logic        mode_ff;

   logic [31:0] t01_ff, t12_ff, t20_ff;
   logic [47:0] base_ff;
   logic [63:0] lterm_ff, rterm_ff;

   sahss_pkg::box_type in_box, cbox, suf_new;
   logic [15:0] e0, e1, e2;
   logic [47:0] mul_a;
   logic [15:0] mul_b;
   logic [63:0] mul_p;
   logic [63:0] total;
   logic [sahss_pkg::IdxBits-1:0] suf_addr;

   // incoming box
   assign in_box = '{lo_x: req.box_min_x, lo_y: req.box_min_y, lo_z: req.box_min_z,
                     hi_x: req.box_max_x, hi_y: req.box_max_y, hi_z: req.box_max_z};

   assign suf_new  = sahss_pkg::unite(acc_ff, box_rd_ff);
   assign suf_addr = cmd.idx + 1'b1;

   // memory ports
   always_ff @(posedge clock) begin
      if (cmd.op == sahss_pkg::OP_STORE) box_mem[cmd.idx] <= in_box;
      if (cmd.op == sahss_pkg::OP_SUF_WR) suf_mem[cmd.idx] <= suf_new;
      box_rd_ff <= box_mem[cmd.idx];
      suf_rd_ff <= suf_mem[suf_addr];
   end

   // unions
   always_comb begin
      acc_in = acc_ff;
      pre_in = pre_ff;
      case (cmd.op)
         sahss_pkg::OP_STORE: begin
            acc_in = sahss_pkg::empty_box();
            pre_in = sahss_pkg::empty_box();
         end
         sahss_pkg::OP_SUF_WR: acc_in = suf_new;
         sahss_pkg::OP_FW_UNI: pre_in = sahss_pkg::unite(pre_ff, box_rd_ff);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      pre_ff <= pre_in;
      if (cmd.op == sahss_pkg::OP_FW_UNI) right_ff <= suf_rd_ff;
   end

   // shared multiplier
   assign cbox = cmd.side ? right_ff : pre_ff;
   assign e0 = sahss_pkg::extent(cbox.hi_x, cbox.lo_x);
   assign e1 = sahss_pkg::extent(cbox.hi_y, cbox.lo_y);
   assign e2 = sahss_pkg::extent(cbox.hi_z, cbox.lo_z);

   always_comb begin
      mul_a = 48'(e0);
      mul_b = e1;
      case (cmd.step)
         sahss_pkg::CS_E01: begin mul_a = 48'(e0); mul_b = e1; end
         sahss_pkg::CS_E12: begin mul_a = 48'(e1); mul_b = e2; end
         sahss_pkg::CS_E20: begin mul_a = 48'(e2); mul_b = e0; end
         sahss_pkg::CS_BASE: begin mul_a = 48'(t01_ff); mul_b = e2; end
         sahss_pkg::CS_SCALE: begin mul_a = base_ff; mul_b = 16'(cmd.cnt); end
         default: ;
      endcase
   end

   assign mul_p = 64'(mul_a) * 64'(mul_b);

   always_ff @(posedge clock) begin
      if (cmd.op == sahss_pkg::OP_COST) begin
         case (cmd.step)
            sahss_pkg::CS_E01: t01_ff <= mul_p[31:0];
            sahss_pkg::CS_E12: t12_ff <= mul_p[31:0];
            sahss_pkg::CS_E20: t20_ff <= mul_p[31:0];
            sahss_pkg::CS_BASE: begin
               if (mode_ff) base_ff <= mul_p[47:0];
               else base_ff <= 48'({(34'(t01_ff) + 34'(t12_ff) + 34'(t20_ff)), 1'b0});
            end
            sahss_pkg::CS_SCALE: begin
               if (cmd.side) rterm_ff <= mul_p;
               else lterm_ff <= mul_p;
            end
            default: ;
         endcase
      end
   end

   // best split tracking
   assign total = lterm_ff + rterm_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.op == sahss_pkg::OP_CLEAR) begin
         best_cost_ff  <= '1;
         best_axis_ff  <= sahss_pkg::AxisX;
         best_split_ff <= '0;
         best_l_ff     <= sahss_pkg::empty_box();
         best_r_ff     <= sahss_pkg::empty_box();
      end else if (cmd.op == sahss_pkg::OP_CMP && total < best_cost_ff) begin
         best_cost_ff  <= total;
         best_axis_ff  <= cmd.axis;
         best_split_ff <= cmd.idx;
         best_l_ff     <= pre_ff;
         best_r_ff     <= right_ff;
      end
   end

   // cost mode register
   always_ff @(posedge clock) begin
      if (reset) mode_ff <= 1'b0;
      else if (csr_wr_en) mode_ff <= csr_wr_data;
   end

   // result payload
   always_comb begin
      sahss_pkg::box_type ob;
      ob = cmd.out_side ? best_r_ff : best_l_ff;
      rsp.best_axis = best_axis_ff;
      rsp.split_pos = 10'(best_split_ff);
      rsp.side      = cmd.out_side;
      rsp.out_min_x = ob.lo_x;
      rsp.out_min_y = ob.lo_y;
      rsp.out_min_z = ob.lo_z;
      rsp.out_max_x = ob.hi_x;
      rsp.out_max_y = ob.hi_y;
      rsp.out_max_z = ob.hi_z;
      rsp.last      = cmd.out_side;
   end

endmodule

`default_nettype wire

/* sv/sahss_ctrl.sv */
// ----------------------------------------------------------------------------
// sahss_ctrl - sequencer of the SAH split sweep
// Loads boxes, runs the backward suffix pass, the forward cost pass and the
// two result requests.
// ----------------------------------------------------------------------------
`default_nettype none

module sahss_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire [1:0]            req_axis,
   input  wire                  req_last,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output sahss_pkg::cmd_type   cmd
);

   sahss_pkg::state_type state_ff, state_in;
   logic [sahss_pkg::CntBits-1:0] count_ff, count_in;
   logic [sahss_pkg::IdxBits-1:0] idx_ff, idx_in;
   sahss_pkg::cstep_type step_ff, step_in;
   logic side_ff, side_in;
   logic [1:0] axis_ff, axis_in;

   logic                          room;
   logic [sahss_pkg::CntBits-1:0] n_new;

   assign room  = count_ff < sahss_pkg::CntBits'(sahss_pkg::MaxLeaves);
   assign n_new = count_ff + sahss_pkg::CntBits'(room);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sahss_pkg::ST_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
         step_ff  <= sahss_pkg::CS_E01;
         side_ff  <= 1'b0;
         axis_ff  <= sahss_pkg::AxisX;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         step_ff  <= step_in;
         side_ff  <= side_in;
         axis_ff  <= axis_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      step_in  = step_ff;
      side_in  = side_ff;
      axis_in  = axis_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd.op       = sahss_pkg::OP_NONE;
      cmd.step     = step_ff;
      cmd.side     = side_ff;
      cmd.idx      = idx_ff;
      cmd.cnt      = side_ff ? (count_ff - 1'b1 - sahss_pkg::CntBits'(idx_ff))
                             : (sahss_pkg::CntBits'(idx_ff) + 1'b1);
      cmd.axis     = axis_ff;
      cmd.out_side = 1'b0;

      case (state_ff)
         sahss_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid && req_axis != sahss_pkg::AxisNone) begin
               if (room) begin
                  cmd.op  = sahss_pkg::OP_STORE;
                  cmd.idx = count_ff[sahss_pkg::IdxBits-1:0];
               end
               count_in = n_new;
               if (req_last) begin
                  axis_in = req_axis;
                  idx_in  = sahss_pkg::IdxBits'(n_new - 1'b1);
                  if (n_new >= sahss_pkg::CntBits'(2)) begin
                     state_in = sahss_pkg::ST_SUF_RD;
                  end else begin
                     count_in = '0;
                     if (req_axis == sahss_pkg::AxisZ) state_in = sahss_pkg::ST_EMIT_L;
                  end
               end
            end
         end
         // backward suffix pass
         sahss_pkg::ST_SUF_RD: begin
            cmd.op = sahss_pkg::OP_SUF_RD;
            state_in = sahss_pkg::ST_SUF_WR;
         end
         sahss_pkg::ST_SUF_WR: begin
            cmd.op = sahss_pkg::OP_SUF_WR;
            if (idx_ff == '0) begin
               state_in = sahss_pkg::ST_FW_RD;
            end else begin
               idx_in   = idx_ff - 1'b1;
               state_in = sahss_pkg::ST_SUF_RD;
            end
         end
         // forward cost pass
         sahss_pkg::ST_FW_RD: begin
            cmd.op = sahss_pkg::OP_FW_RD;
            state_in = sahss_pkg::ST_FW_UNI;
         end
         sahss_pkg::ST_FW_UNI: begin
            cmd.op   = sahss_pkg::OP_FW_UNI;
            step_in  = sahss_pkg::CS_E01;
            side_in  = 1'b0;
            state_in = sahss_pkg::ST_COST;
         end
         sahss_pkg::ST_COST: begin
            cmd.op = sahss_pkg::OP_COST;
            case (step_ff)
               sahss_pkg::CS_E01: step_in = sahss_pkg::CS_E12;
               sahss_pkg::CS_E12: step_in = sahss_pkg::CS_E20;
               sahss_pkg::CS_E20: step_in = sahss_pkg::CS_BASE;
               sahss_pkg::CS_BASE: step_in = sahss_pkg::CS_SCALE;
               default: begin
                  step_in = sahss_pkg::CS_E01;
                  if (side_ff) state_in = sahss_pkg::ST_CMP;
                  else side_in = 1'b1;
               end
            endcase
         end
         sahss_pkg::ST_CMP: begin
            cmd.op = sahss_pkg::OP_CMP;
            if (sahss_pkg::CntBits'(idx_ff) + 2'd2 == count_ff) begin
               count_in = '0;
               state_in = (axis_ff == sahss_pkg::AxisZ) ? sahss_pkg::ST_EMIT_L
                                                        : sahss_pkg::ST_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = sahss_pkg::ST_FW_RD;
            end
         end
         // two result requests
         sahss_pkg::ST_EMIT_L: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = sahss_pkg::ST_EMIT_R;
         end
         sahss_pkg::ST_EMIT_R: begin
            rsp_valid    = 1'b1;
            cmd.out_side = 1'b1;
            if (!rsp_stall) begin
               cmd.op   = sahss_pkg::OP_CLEAR;
               state_in = sahss_pkg::ST_IDLE;
            end
         end
         default: state_in = sahss_pkg::ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

/* sv/sah_split_sweep.sv */
// ----------------------------------------------------------------------------
// sah_split_sweep - SAH best-split search over sorted boxes
// Sequencer plus datapath; reports left and right child boxes of the
// cheapest split after the z group ends.
// ----------------------------------------------------------------------------
//  channel  ports                                direction
//  req      req_valid req_stall req_data         in   one box request
//  rsp      rsp_valid rsp_stall rsp_data         out  child box result
//  csr      csr_wr_en csr_wr_data                in   cost mode write
//
// Loading takes one cycle per box while requests are not stalled. A group
// of n >= 2 boxes then runs a backward suffix pass and a cost pass over
// its n-1 splits, which share the single 48x16 multiplier.
// Requests are stalled from a group end until its sweep and results finish.
// Reset is synchronous; the memories hold no reset state.
`default_nettype none

module sah_split_sweep (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  sahss_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output sahss_pkg::rsp_type  rsp_data,
   input  wire                 csr_wr_en,
   input  wire                 csr_wr_data
);

   sahss_pkg::cmd_type cmd;

   sahss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_axis  (req_data.axis),
      .req_last  (req_data.last_of_axis),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   sahss_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req         (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp         (rsp_data)
   );

   // no request taken while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid) else $error("request taken during result");

   // left result is always followed by the right one
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=> rsp_valid && rsp_data.last)
      else $error("right result missing");

   // nothing more after the final result
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.last |=> !rsp_valid && !req_stall)
      else $error("extra result");

endmodule

`default_nettype wire

/* sim/tb_sah_split_sweep.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sah_split_sweep - self-checking bench for the SAH split sweep
// Sends box groups for the three axes, predicts the two child boxes of
// the cheapest split in a local model and compares every result field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sah_split_sweep;

   localparam int Leaves    = 1024;
   localparam int CycleCap  = 3000000;
   localparam int LongHold  = 400;

   typedef struct {
      int lo[3];
      int hi[3];
   } geo_box_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   sahss_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   sahss_pkg::rsp_type rsp_data;
   logic    csr_wr_en = 1'b0;
   logic    csr_wr_data = 1'b0;

   sah_split_sweep u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // split-search model state
   geo_box_type group_boxes[Leaves];
   int          group_count;
   logic [63:0] best_cost;
   logic [1:0]  best_axis;
   logic [9:0]  best_split;
   geo_box_type best_left;
   geo_box_type best_right;
   logic        area_or_volume;

   sahss_pkg::rsp_type child_queue[$];
   int          errors = 0;
   int          cycles = 0;
   bit          rx_idle_on = 1'b1;
   bit          tx_idle_on = 1'b1;
   int          burst_left = 0;
   bit          long_hold = 1'b0;
   event        start_hold;

   function automatic geo_box_type empty_geo();
      geo_box_type b;
      for (int k = 0; k < 3; k++) begin
         b.lo[k] = 32767;
         b.hi[k] = -32768;
      end
      return b;
   endfunction

   function automatic geo_box_type merge_geo(geo_box_type a, geo_box_type b);
      for (int k = 0; k < 3; k++) begin
         if (b.lo[k] < a.lo[k]) a.lo[k] = b.lo[k];
         if (b.hi[k] > a.hi[k]) a.hi[k] = b.hi[k];
      end
      return a;
   endfunction

   function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return (p[127:64] != 0) ? '1 : p[63:0];
   endfunction

   function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = 65'(a) + 65'(b);
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic logic [63:0] geo_cost(geo_box_type b);
      logic [63:0] e[3];
      int d;
      for (int k = 0; k < 3; k++) begin
         d = b.hi[k] - b.lo[k];
         e[k] = (d > 0) ? 64'(d) : 64'd0;
      end
      if (area_or_volume) return e[0] * e[1] * e[2];
      return 64'd2 * (e[0] * e[1] + e[1] * e[2] + e[2] * e[0]);
   endfunction

   function automatic void clear_best();
      best_cost  = '1;
      best_axis  = sahss_pkg::AxisX;
      best_split = '0;
      best_left  = empty_geo();
      best_right = empty_geo();
   endfunction

   function automatic sahss_pkg::rsp_type child_of(geo_box_type b, logic side);
      sahss_pkg::rsp_type r;
      r.best_axis = best_axis;
      r.split_pos = best_split;
      r.side      = side;
      r.out_min_x = 16'(b.lo[0]); r.out_min_y = 16'(b.lo[1]); r.out_min_z = 16'(b.lo[2]);
      r.out_max_x = 16'(b.hi[0]); r.out_max_y = 16'(b.hi[1]); r.out_max_z = 16'(b.hi[2]);
      r.last      = side;
      return r;
   endfunction

   // sweep one finished group and keep the first cheapest split
   function automatic void sweep_group(logic [1:0] ax);
      geo_box_type suffix[Leaves];
      geo_box_type acc;
      geo_box_type prefix;
      logic [63:0] c;
      int n;
      n = group_count;
      if (n < 2) return;
      acc = empty_geo();
      for (int i = n - 1; i >= 0; i--) begin
         acc = merge_geo(acc, group_boxes[i]);
         suffix[i] = acc;
      end
      prefix = empty_geo();
      for (int s = 0; s + 1 < n; s++) begin
         prefix = merge_geo(prefix, group_boxes[s]);
         c = add_sat(mul_sat(geo_cost(prefix), 64'(s + 1)),
                     mul_sat(geo_cost(suffix[s + 1]), 64'(n - s - 1)));
         if (c < best_cost) begin
            best_cost  = c;
            best_axis  = ax;
            best_split = s[9:0];
            best_left  = prefix;
            best_right = suffix[s + 1];
         end
      end
   endfunction

   function automatic void predict_split(sahss_pkg::req_type r);
      geo_box_type b;
      if (r.axis == sahss_pkg::AxisNone) return;
      if (group_count < Leaves) begin
         b.lo[0] = int'(r.box_min_x); b.lo[1] = int'(r.box_min_y);
         b.lo[2] = int'(r.box_min_z);
         b.hi[0] = int'(r.box_max_x); b.hi[1] = int'(r.box_max_y);
         b.hi[2] = int'(r.box_max_z);
         group_boxes[group_count] = b;
         group_count++;
      end
      if (!r.last_of_axis) return;
      sweep_group(r.axis);
      group_count = 0;
      if (r.axis != sahss_pkg::AxisZ) return;
      child_queue.push_back(child_of(best_left, 1'b0));
      child_queue.push_back(child_of(best_right, 1'b1));
      clear_best();
   endfunction

   // send one box request; prediction happens at acceptance
   task automatic send_box(sahss_pkg::req_type r);
      int gap;
      if (tx_idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_split(r);
      @(negedge clock);
   endtask

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 200)) - 16'd100;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic sahss_pkg::req_type rand_box(logic [1:0] ax, logic last_mark);
      sahss_pkg::req_type r;
      logic signed [15:0] a, b;
      r.axis = ax;
      r.last_of_axis = last_mark;
      a = rand_coord(); b = rand_coord();
      if ($urandom_range(0, 9) != 0 && a > b) begin
         r.box_min_x = b; r.box_max_x = a;
      end else begin
         r.box_min_x = a; r.box_max_x = b;
      end
      a = rand_coord(); b = rand_coord();
      if ($urandom_range(0, 9) != 0 && a > b) begin
         r.box_min_y = b; r.box_max_y = a;
      end else begin
         r.box_min_y = a; r.box_max_y = b;
      end
      a = rand_coord(); b = rand_coord();
      if ($urandom_range(0, 9) != 0 && a > b) begin
         r.box_min_z = b; r.box_max_z = a;
      end else begin
         r.box_min_z = a; r.box_max_z = b;
      end
      return r;
   endfunction

   task automatic send_group(logic [1:0] ax, int n);
      for (int i = 0; i < n; i++) send_box(rand_box(ax, i == n - 1));
   endtask

   // full node: three groups x, y, z
   task automatic send_node(int max_n);
      for (int ax = 0; ax < 3; ax++) send_group(ax[1:0], $urandom_range(1, max_n));
   endtask

   // stop sending, wait for all results and for the block to go idle
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (child_queue.size() != 0) @(negedge clock);
      while (req_stall) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_cost_mode(logic value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      area_or_volume = value;
   endtask

   // directed: extremes, single boxes, no candidate, ignored axis, odd order
   task automatic test_directed();
      sahss_pkg::req_type r;
      r = '0;
      r.axis = sahss_pkg::AxisZ; r.last_of_axis = 1'b1;
      send_box(r);
      r.axis = sahss_pkg::AxisNone; r.box_min_x = 16'h8000; r.box_max_y = 16'h7FFF;
      send_box(r);
      r = '{axis: 2'd0, box_min_x: 16'h8000, box_min_y: 16'h8000, box_min_z: 16'h8000,
            box_max_x: 16'h7FFF, box_max_y: 16'h7FFF, box_max_z: 16'h7FFF,
            last_of_axis: 1'b0};
      send_box(r);
      r.last_of_axis = 1'b1;
      send_box(r);
      r = '{axis: 2'd1, box_min_x: 16'h7FFF, box_min_y: 16'h7FFF, box_min_z: 16'h7FFF,
            box_max_x: 16'h8000, box_max_y: 16'h8000, box_max_z: 16'h8000,
            last_of_axis: 1'b0};
      send_box(r);
      send_box(rand_box(2'd1, 1'b1));
      send_group(sahss_pkg::AxisZ, 2);
      // groups out of order, axis 2 first then 0 then 2
      send_group(sahss_pkg::AxisZ, 3);
      send_group(sahss_pkg::AxisX, 4);
      send_group(sahss_pkg::AxisZ, 5);
      wait_drained();
   endtask

   // store overflow: more boxes than leaves in one group
   task automatic test_store_full();
      send_group(sahss_pkg::AxisX, Leaves + 3);
      send_group(sahss_pkg::AxisZ, 2);
      wait_drained();
   endtask

   // long receiver hold while requests keep coming
   task automatic test_back_pressure();
      -> start_hold;
      send_node(6);
      send_node(6);
      wait_drained();
   endtask

   task automatic test_random(int items);
      int sent;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(0, 9) == 0) begin
            send_box(rand_box(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
            sent++;
         end else begin
            send_node(12);
            sent += 18;
         end
      end
      wait_drained();
   endtask

   // long receiver hold, counted in its own process
   always begin
      @(start_hold);
      long_hold = 1'b1;
      repeat (LongHold) @(negedge clock);
      long_hold = 1'b0;
   end

   // receiver stall: random bursts plus the long hold
   always @(negedge clock) begin
      if (long_hold) begin
         rsp_stall   <= 1'b1;
      end else if (burst_left > 0) begin
         rsp_stall   <= 1'b1;
         burst_left  <= burst_left - 1;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
         rsp_stall   <= 1'b1;
         burst_left  <= $urandom_range(0, 18);
      end else begin
         rsp_stall   <= 1'b0;
      end
   end

   // result checker
   always @(posedge clock) begin
      sahss_pkg::rsp_type want;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (child_queue.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            want = child_queue.pop_front();
            if (want !== rsp_data) begin
               errors++;
               if (errors <= 10) $display("mismatch: expected %p got %p", want, rsp_data);
            end
         end
      end
      if (cycles > CycleCap) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      group_count = 0;
      area_or_volume = 1'b0;
      clear_best();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      write_cost_mode(1'b1);
      test_directed();
      test_store_full();
      test_back_pressure();
      write_cost_mode(1'b0);
      test_random(330);
      write_cost_mode(1'b1);
      test_random(280);
      // last part runs without idling
      write_cost_mode(1'b0);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      test_random(190);
      wait_drained();
      repeat (100) @(negedge clock);
      if (errors == 0 && child_queue.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
